// ===== design/frame_bitmap_allocator_top_assert.svh =====
// assertion macros used by the frame bitmap allocator datapath
`ifndef FRAME_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fba_pkg.sv =====
// shared types and constants of the frame bitmap allocator
package fba_pkg;

  localparam int FRAME_W  = 12;
  localparam int LIMIT_W  = 13;
  localparam int STATUS_W = 3;

  // frames reachable through the frame number field
  localparam int FRAME_SPACE = 4096;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  // request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOCATED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HAD_FRAME    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FREE      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE_TO_FREE = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic                clear;
    logic                load;
    logic                scan_start;
    logic                scan_run;
    logic                set_bit;
    logic                free_div;
    logic                free_rd;
    logic                free_wr;
    logic                res_set;
    logic [STATUS_W-1:0] res_status;
    logic                push;
  } fba_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic op_free;
    logic cur_zero;
    logic found;
    logic exhausted;
    logic out_free;
  } fba_stat_t;

endpackage

// ===== design/fba_ctrl.sv =====
// request sequencer of the frame bitmap allocator
module fba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fba_pkg::fba_stat_t stat_i,
  output fba_pkg::fba_cmd_t  cmd_o
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DISPATCH = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_FREE_DIV = 3'd4;
  localparam logic [2:0] S_FREE_RD  = 3'd5;
  localparam logic [2:0] S_FREE_WR  = 3'd6;
  localparam logic [2:0] S_RESP     = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (!stat_i.op_free && !stat_i.cur_zero) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = fba_pkg::ST_HAD_FRAME;
          state_d          = S_RESP;
        end else if (stat_i.op_free && stat_i.cur_zero) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = fba_pkg::ST_NONE_TO_FREE;
          state_d          = S_RESP;
        end else if (stat_i.op_free) begin
          state_d = S_FREE_DIV;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        priority if (stat_i.found) begin
          cmd_o.set_bit    = 1'b1;
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = fba_pkg::ST_ALLOCATED;
          state_d          = S_RESP;
        end else if (stat_i.exhausted) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = fba_pkg::ST_NO_FREE;
          state_d          = S_RESP;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_FREE_DIV: begin
        cmd_o.free_div = 1'b1;
        state_d        = S_FREE_RD;
      end
      S_FREE_RD: begin
        cmd_o.free_rd = 1'b1;
        state_d       = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd_o.free_wr    = 1'b1;
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = fba_pkg::ST_FREED;
        state_d          = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // state register, clearing pass first after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/fba_datapath.sv =====
// bitmap memory, word scan, free address split and result registers
module fba_datapath #(
  parameter int MAX_FRAMES = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fba_pkg::LIMIT_W-1:0]      cfg_wdata_i,
  input  logic                             op_i,
  input  logic [fba_pkg::FRAME_W-1:0]      current_frame_i,
  input  logic                             want_supervisor_i,
  input  logic                             want_write_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fba_pkg::STATUS_W-1:0]     status_o,
  output logic [fba_pkg::FRAME_W-1:0]      new_frame_o,
  output logic                             present_o,
  output logic                             writable_o,
  output logic                             supervisor_o,
  input  fba_pkg::fba_cmd_t                cmd_i,
  output fba_pkg::fba_stat_t               stat_o
);

  `include "frame_bitmap_allocator_top_assert.svh"

  localparam int FW = fba_pkg::FRAME_W;
  localparam int LW = fba_pkg::LIMIT_W;
  localparam int SW = fba_pkg::STATUS_W;

  localparam int NUM_WORDS     = MAX_FRAMES / WORD_BITS;
  localparam int SPACE_WORDS   = fba_pkg::FRAME_SPACE / WORD_BITS;
  localparam int MEM_WORDS_RAW = (NUM_WORDS < SPACE_WORDS) ? NUM_WORDS : SPACE_WORDS;
  localparam int MEM_WORDS     = (MEM_WORDS_RAW < 1) ? 1 : MEM_WORDS_RAW;
  localparam int AW            = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int BW            = $clog2(WORD_BITS);
  localparam int LIM_CAP       = (MAX_FRAMES < fba_pkg::FRAME_SPACE) ?
                                 MAX_FRAMES : fba_pkg::FRAME_SPACE;
  // frame / WORD_BITS as a multiply by a rounded-up reciprocal, exact for 12-bit frames
  localparam int DIV_SH  = FW + BW;
  localparam int RECIP   = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W = FW + 2;
  localparam int PROD_W  = FW + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_C   = RECIP_W'(RECIP);
  localparam logic [LW-1:0]      LIM_CAP_C = LW'(LIM_CAP);
  localparam logic [LW:0]        WB_STEP   = (LW + 1)'(WORD_BITS);
  localparam logic [FW-1:0]      WB_FRAME  = FW'(WORD_BITS);
  localparam logic [FW-1:0]      MEM_WORDS_C = FW'(MEM_WORDS);
  localparam logic [AW-1:0]      LAST_ADDR = AW'(MEM_WORDS - 1);

  // configuration and request registers
  logic [LW-1:0] frame_limit_q;
  logic          op_q;
  logic [FW-1:0] cur_q;
  logic          sup_q, wr_q;

  // bitmap memory and its read register
  logic [WORD_BITS-1:0] frame_used_q [MEM_WORDS];
  logic [WORD_BITS-1:0] mem_rdata_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // scan pipeline
  logic [AW-1:0] iss_idx_q, rd_idx_q, clr_addr_q;
  logic [LW-1:0] iss_base_q, rd_base_q, lim_eff;
  logic          rd_vld_q, issue_ok;
  logic [LW:0]   iss_next;

  // free address split
  logic [PROD_W-1:0]    div_prod;
  logic [FW-1:0]        div_q, div_rem;
  logic [BW-1:0]        bit_q, zero_bit;
  logic                 div_in_range;
  logic [WORD_BITS-1:0] zero_onehot, free_mask;

  // result and output registers
  logic [SW-1:0] res_status_q, out_status_q;
  logic [FW-1:0] res_frame_q, out_frame_q;
  logic          res_present_q, res_writable_q, res_supervisor_q;
  logic          out_present_q, out_writable_q, out_supervisor_q;
  logic          out_valid_q;
  logic          res_alloc;

  // search limit capped by the map and the frame field
  assign lim_eff  = (frame_limit_q > LIM_CAP_C) ? LIM_CAP_C : frame_limit_q;
  assign iss_next = {1'b0, iss_base_q} + WB_STEP;
  assign issue_ok = (iss_next <= {1'b0, lim_eff});

  // lowest clear bit of the word under test
  always_comb begin
    zero_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!mem_rdata_q[i]) begin
        zero_bit = BW'(i);
      end
    end
  end
  assign zero_onehot = {{(WORD_BITS - 1){1'b0}}, 1'b1} << zero_bit;
  assign free_mask   = ~({{(WORD_BITS - 1){1'b0}}, 1'b1} << bit_q);

  // word index and bit of the frame being freed
  assign div_prod     = PROD_W'(cur_q) * PROD_W'(RECIP_C);
  assign div_rem      = cur_q - FW'(div_q * WB_FRAME);
  assign div_in_range = (div_q < MEM_WORDS_C);

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = '0;
    priority if (cmd_i.clear) begin
      mem_we = 1'b1;
    end else if (cmd_i.set_bit) begin
      mem_we    = 1'b1;
      mem_waddr = rd_idx_q;
      mem_wdata = mem_rdata_q | zero_onehot;
    end else if (cmd_i.free_wr && div_in_range) begin
      mem_we    = 1'b1;
      mem_waddr = div_q[AW-1:0];
      mem_wdata = mem_rdata_q & free_mask;
    end else begin
      mem_we = 1'b0;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = iss_idx_q;
    priority if (cmd_i.scan_run && issue_ok) begin
      mem_re = 1'b1;
    end else if (cmd_i.free_rd) begin
      mem_re    = 1'b1;
      mem_raddr = div_q[AW-1:0];
    end else begin
      mem_re = 1'b0;
    end
  end

  // bitmap memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_used_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= frame_used_q[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q <= fba_pkg::LIMIT_RESET;
      clr_addr_q    <= '0;
      rd_vld_q      <= 1'b0;
      iss_idx_q     <= '0;
      iss_base_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_limit_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (cmd_i.scan_start) begin
        iss_idx_q  <= '0;
        iss_base_q <= '0;
        rd_vld_q   <= 1'b0;
      end else if (cmd_i.scan_run) begin
        rd_vld_q <= issue_ok;
        if (issue_ok) begin
          iss_idx_q  <= iss_idx_q + AW'(1);
          iss_base_q <= iss_next[LW-1:0];
        end
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  assign res_alloc = (cmd_i.res_status == fba_pkg::ST_ALLOCATED);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      cur_q <= current_frame_i;
      sup_q <= want_supervisor_i;
      wr_q  <= want_write_i;
    end
    if (cmd_i.scan_run) begin
      rd_idx_q  <= iss_idx_q;
      rd_base_q <= iss_base_q;
    end
    if (cmd_i.free_div) begin
      div_q <= FW'(div_prod >> DIV_SH);
    end
    if (cmd_i.free_rd) begin
      bit_q <= div_rem[BW-1:0];
    end
    if (cmd_i.res_set) begin
      res_status_q     <= cmd_i.res_status;
      res_present_q    <= res_alloc;
      res_writable_q   <= res_alloc & wr_q;
      res_supervisor_q <= res_alloc & sup_q;
      priority if (res_alloc) begin
        res_frame_q <= FW'(rd_base_q + LW'(zero_bit));
      end else if (cmd_i.res_status == fba_pkg::ST_HAD_FRAME) begin
        res_frame_q <= cur_q;
      end else begin
        res_frame_q <= '0;
      end
    end
    if (cmd_i.push) begin
      out_status_q     <= res_status_q;
      out_frame_q      <= res_frame_q;
      out_present_q    <= res_present_q;
      out_writable_q   <= res_writable_q;
      out_supervisor_q <= res_supervisor_q;
    end
  end

  // status to the controller
  assign stat_o.clr_done  = (clr_addr_q == LAST_ADDR);
  assign stat_o.op_free   = (op_q == fba_pkg::OP_FREE);
  assign stat_o.cur_zero  = (cur_q == '0);
  assign stat_o.found     = rd_vld_q && (mem_rdata_q != '1);
  assign stat_o.exhausted = !rd_vld_q && !issue_ok;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign new_frame_o  = out_frame_q;
  assign present_o    = out_present_q;
  assign writable_o   = out_writable_q;
  assign supervisor_o = out_supervisor_q;

  // checks
  `FBA_ASSERT_NOW(a_push_slot_free, cmd_i.push, (!out_valid_q || out_ready_i),
    "result word overwritten before it was taken")
  `FBA_ASSERT_NOW(a_flags_only_alloc,
    out_valid_q && (out_status_q != fba_pkg::ST_ALLOCATED),
    (!out_present_q && !out_writable_q && !out_supervisor_q),
    "page flags set on a result that is not an allocation")
  `FBA_ASSERT_NOW(a_scan_in_limit, cmd_i.scan_run && issue_ok, (iss_base_q < LIM_CAP_C),
    "scan read beyond the frame map")
  `FBA_ASSERT_NEXT(a_push_sets_valid, cmd_i.push, out_valid_q,
    "pushed result word not presented")

endmodule

// ===== design/frame_bitmap_allocator_top.sv =====
// frame bitmap allocator: first-fit page frame allocator, top level
// sequence: allocate with a zero frame scans up to W words (frame limit / word size, 128 by
//   default); other allocate and empty free answer from dispatch; free divides, reads, writes
// throughput: one request at a time through one bitmap read port; next request accepted once
//   the result word is pushed to the output register, which waits until the last one is taken
// reset: clearing pass of one bitmap word per cycle (128 by default) before the first word
module frame_bitmap_allocator_top #(
  parameter int MAX_FRAMES = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fba_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [fba_pkg::FRAME_W-1:0]  current_frame_i,
  input  logic                         want_supervisor_i,
  input  logic                         want_write_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fba_pkg::STATUS_W-1:0] status_o,
  output logic [fba_pkg::FRAME_W-1:0]  new_frame_o,
  output logic                         present_o,
  output logic                         writable_o,
  output logic                         supervisor_o
);

  fba_pkg::fba_cmd_t  cmd;
  fba_pkg::fba_stat_t stat;

  // request sequencer
  fba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // bitmap and result datapath
  fba_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .op_i              (op_i),
    .current_frame_i   (current_frame_i),
    .want_supervisor_i (want_supervisor_i),
    .want_write_i      (want_write_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .new_frame_o       (new_frame_o),
    .present_o         (present_o),
    .writable_o        (writable_o),
    .supervisor_o      (supervisor_o),
    .cmd_i             (cmd),
    .stat_o            (stat)
  );

endmodule
